// File: src/lbsb_pkg.sv
// Shared types, constants and the band-end table builder for the log band
// spectrum bars block. No dependencies.
`default_nettype none
package lbsb_pkg;

	localparam int PowerW  = 16;
	localparam int BinW    = 13;
	localparam int SumW    = 28;
	localparam int LevelW  = 16;
	localparam int IdxW    = 6;
	localparam int BandW   = 7;
	localparam int RomW    = 11;
	localparam int RomN    = 64;
	localparam int RadW    = 44;
	localparam int RootW   = 22;
	localparam int RemW    = 25;
	localparam int StepW   = 5;
	localparam int FifoDepth = 4;

	localparam int RootSteps  = 16;
	localparam int DivSteps   = 28;
	localparam int LevelSteps = 22;

	localparam logic [BinW-1:0] MaxBins = 13'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DIV,
		ST_LVL,
		ST_PUSH
	} eng_state_t;

	typedef struct packed {
		logic [PowerW-1:0] bin_power;
		logic              last_bin;
	} item_t;

	typedef struct packed {
		logic [IdxW-1:0]   bar_index;
		logic [LevelW-1:0] bar_level;
		logic [SumW-1:0]   frame_energy;
		logic              last_bar;
	} result_t;

	typedef logic [RomW-1:0] band_rom_t [RomN];

	// Band end i < bars is the largest k with k^d <= 2^(10*i), d being bars-1;
	// others are 0. Bisection finds it between consecutive powers of two.
	function automatic band_rom_t build_band_rom(int bars);
		band_rom_t tab;
		int        d;
		int        n;
		int        q;
		int        lo;
		int        hi;
		int        mid;
		d = (bars > 1) ? bars - 1 : 1;
		for (int i = 0; i < RomN; i++) begin
			n = i * 10;
			q = 0;
			for (int t = 1; t <= 10; t++) begin
				if (t * d <= n)
					q = t;
			end
			lo = 1 << q;
			hi = (2 << q) - 1;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (real'(mid) ** real'(d) <= 2.0 ** real'(n))
					lo = mid;
				else
					hi = mid - 1;
			end
			if (i >= bars)
				lo = 0;
			tab[i] = lo[RomW-1:0];
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// File: src/log_band_spectrum_bars_unit.sv
// Top level of the log band spectrum bars block: input queue, back end and
// result queue. Depends on lbsb_pkg, lbsb_fifo and lbsb_engine.
`default_nettype none
// Bins enter a four-deep queue, so a burst of up to four bins is taken one per
// clock. The back end pops a bin only when idle and forms its root with the
// 16-step bit-serial square root before it takes the next bin. Each band that
// closes then adds 28 division steps, 22 level root steps and a push state
// that hands the result to the two-deep result queue and waits while it is
// full. On the final bin every band still open is closed in turn, so a frame
// that ends early runs these steps once per band before the next bin starts.
module log_band_spectrum_bars_unit #(
	parameter int BARS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lbsb_pkg::BinW-1:0]     cfg_data,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [lbsb_pkg::PowerW-1:0]   bin_power,
	input  wire logic                          last_bin,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [lbsb_pkg::IdxW-1:0]          bar_index,
	output logic [lbsb_pkg::LevelW-1:0]        bar_level,
	output logic [lbsb_pkg::SumW-1:0]          frame_energy,
	output logic                               last_bar
);
	localparam int ItemW = $bits(lbsb_pkg::item_t);
	localparam int ResW  = $bits(lbsb_pkg::result_t);

	logic [lbsb_pkg::BinW-1:0] fft_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fft_bins_q <= lbsb_pkg::BinW'(512);
		else if (cfg_we)
			fft_bins_q <= cfg_data;
	end

	lbsb_pkg::item_t   in_wr;
	logic [ItemW-1:0]  in_rd;
	logic              in_empty;
	logic              in_pop;
	lbsb_pkg::result_t eng_res;
	logic [ResW-1:0]   out_rd;
	lbsb_pkg::result_t out_res;
	logic              out_full;
	logic              out_push;

	assign in_wr.bin_power = bin_power;
	assign in_wr.last_bin  = last_bin;

	lbsb_fifo #(
		.WIDTH(ItemW),
		.DEPTH(lbsb_pkg::FifoDepth)
	) u_in_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_wr),
		.full  (full),
		.pop   (in_pop),
		.rdata (in_rd),
		.empty (in_empty)
	);

	lbsb_engine #(
		.BARS(BARS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.fft_bins(fft_bins_q),
		.in_item (lbsb_pkg::item_t'(in_rd)),
		.in_empty(in_empty),
		.in_pop  (in_pop),
		.res     (eng_res),
		.out_full(out_full),
		.out_push(out_push)
	);

	lbsb_fifo #(
		.WIDTH(ResW),
		.DEPTH(2)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (eng_res),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rd),
		.empty (empty)
	);

	assign out_res      = lbsb_pkg::result_t'(out_rd);
	assign bar_index    = out_res.bar_index;
	assign bar_level    = out_res.bar_level;
	assign frame_energy = out_res.frame_energy;
	assign last_bar     = out_res.last_bar;

endmodule
`default_nettype wire

// File: src/lbsb_fifo.sv
// Small first-in first-out queue used on both sides of the back end.
// Depends on nothing but its parameters.
`default_nettype none
module lbsb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int PtrW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [PtrW:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PtrW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: src/lbsb_engine.sv
// Back end: per-bin square root, band accumulation, band division and level
// root, all iterative; the roots share one unit. Depends on lbsb_pkg.
`default_nettype none
module lbsb_engine #(
	parameter int BARS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [lbsb_pkg::BinW-1:0]     fft_bins,
	input  wire lbsb_pkg::item_t               in_item,
	input  wire logic                          in_empty,
	output logic                               in_pop,
	output lbsb_pkg::result_t                  res,
	input  wire logic                          out_full,
	output logic                               out_push
);
	localparam lbsb_pkg::band_rom_t BandRom = lbsb_pkg::build_band_rom(BARS);
	localparam logic [lbsb_pkg::BandW-1:0] LastBand = lbsb_pkg::BandW'(BARS - 1);
	localparam int BinW = lbsb_pkg::BinW;
	localparam int SumW = lbsb_pkg::SumW;

	lbsb_pkg::eng_state_t state_q, state_d;

	logic [lbsb_pkg::StepW-1:0]  step_q;
	logic [lbsb_pkg::PowerW-1:0] p_q;
	logic                        last_q;
	logic [BinW-1:0]             bin_cnt_q;
	logic [lbsb_pkg::BandW-1:0]  band_idx_q;
	logic [BinW-1:0]             band_start_q;
	logic [BinW-1:0]             band_end_q;
	logic [SumW-1:0]             root_sum_q;
	logic [SumW-1:0]             energy_q;
	logic                        done_q;

	logic [lbsb_pkg::RadW-1:0]   rad_q;
	logic [lbsb_pkg::RemW-1:0]   rem_q;
	logic [lbsb_pkg::RootW-1:0]  root_q;
	logic [SumW-1:0]             dvd_q;
	logic [BinW:0]               drem_q;

	// Shared square root step.
	logic [lbsb_pkg::RemW-1:0]  rem_sh, trial, rem_nx;
	logic                       sq_ge;
	logic [lbsb_pkg::RootW-1:0] root_nx;

	assign rem_sh  = {rem_q[lbsb_pkg::RemW-3:0], rad_q[lbsb_pkg::RadW-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign sq_ge   = (rem_sh >= trial);
	assign rem_nx  = sq_ge ? rem_sh - trial : rem_sh;
	assign root_nx = {root_q[lbsb_pkg::RootW-2:0], sq_ge};

	// Restoring division step: root_sum over the band's bin count.
	logic [BinW-1:0] band_cnt;
	logic [BinW:0]   dr_sh, dr_nx;
	logic            dv_ge;
	logic [SumW-1:0] dvd_nx;

	assign band_cnt = band_end_q - band_start_q;
	assign dr_sh    = {drem_q[BinW-1:0], dvd_q[SumW-1]};
	assign dv_ge    = (dr_sh >= {1'b0, band_cnt});
	assign dr_nx    = dv_ge ? dr_sh - {1'b0, band_cnt} : dr_sh;
	assign dvd_nx   = {dvd_q[SumW-2:0], dv_ge};

	// Saturating accumulation of the current bin.
	logic [SumW:0]   root_add, energy_add;
	logic [SumW-1:0] root_sat, energy_sat;

	assign root_add   = {1'b0, root_sum_q} + (SumW+1)'(root_nx[lbsb_pkg::PowerW-1:0]);
	assign energy_add = {1'b0, energy_q} + (SumW+1)'(p_q);
	assign root_sat   = root_add[SumW] ? '1 : root_add[SumW-1:0];
	assign energy_sat = energy_add[SumW] ? '1 : energy_add[SumW-1:0];

	logic [BinW-1:0] bin_cnt_inc;
	logic            band_close;
	logic            frame_end;
	logic            step_last;

	assign bin_cnt_inc = (bin_cnt_q == '1) ? bin_cnt_q : bin_cnt_q + 1'b1;
	assign band_close  = ({1'b0, bin_cnt_q} + 1'b1) >= {1'b0, band_end_q};
	assign frame_end   = (band_idx_q >= LastBand);

	always_comb begin
		unique case (state_q)
			lbsb_pkg::ST_ROOT: step_last = (step_q == lbsb_pkg::StepW'(lbsb_pkg::RootSteps - 1));
			lbsb_pkg::ST_DIV:  step_last = (step_q == lbsb_pkg::StepW'(lbsb_pkg::DivSteps - 1));
			lbsb_pkg::ST_LVL:  step_last = (step_q == lbsb_pkg::StepW'(lbsb_pkg::LevelSteps - 1));
			default:           step_last = 1'b0;
		endcase
	end

	// Next band end: ROM value, clamped to min(fft_bins,4096)-1, past old end.
	logic [lbsb_pkg::BandW-1:0] nx_idx;
	logic [BinW-1:0]            fb_lim, fb_clip, nx_rom, nx_end;

	assign nx_idx  = band_idx_q + 1'b1;
	assign fb_clip = (fft_bins > lbsb_pkg::MaxBins) ? lbsb_pkg::MaxBins : fft_bins;
	assign fb_lim  = (fb_clip == '0) ? '0 : fb_clip - 1'b1;
	assign nx_rom  = BinW'(BandRom[nx_idx[lbsb_pkg::IdxW-1:0]]);

	always_comb begin
		nx_end = (nx_rom > fb_lim) ? fb_lim : nx_rom;
		if (nx_end <= band_end_q)
			nx_end = band_end_q + 1'b1;
	end

	always_comb begin
		state_d  = state_q;
		in_pop   = 1'b0;
		out_push = 1'b0;
		unique case (state_q)
			lbsb_pkg::ST_IDLE: begin
				if (!in_empty) begin
					in_pop = 1'b1;
					if (!done_q)
						state_d = lbsb_pkg::ST_ROOT;
				end
			end
			lbsb_pkg::ST_ROOT: begin
				if (step_last)
					state_d = (band_close || last_q) ? lbsb_pkg::ST_DIV : lbsb_pkg::ST_IDLE;
			end
			lbsb_pkg::ST_DIV: begin
				if (step_last)
					state_d = lbsb_pkg::ST_LVL;
			end
			lbsb_pkg::ST_LVL: begin
				if (step_last)
					state_d = lbsb_pkg::ST_PUSH;
			end
			lbsb_pkg::ST_PUSH: begin
				if (!out_full) begin
					out_push = 1'b1;
					state_d  = (last_q && !frame_end) ? lbsb_pkg::ST_DIV : lbsb_pkg::ST_IDLE;
				end
			end
			default: state_d = lbsb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		res.bar_index    = band_idx_q[lbsb_pkg::IdxW-1:0];
		res.bar_level    = (root_q > lbsb_pkg::RootW'(16'hFFFF)) ? '1
			: root_q[lbsb_pkg::LevelW-1:0];
		res.frame_energy = energy_q;
		res.last_bar     = (band_idx_q == LastBand);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lbsb_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Unit operands need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			lbsb_pkg::ST_IDLE: begin
				p_q    <= in_item.bin_power;
				rad_q  <= {in_item.bin_power, 28'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			lbsb_pkg::ST_ROOT: begin
				rad_q  <= {rad_q[lbsb_pkg::RadW-3:0], 2'b00};
				rem_q  <= rem_nx;
				root_q <= root_nx;
				dvd_q  <= root_sat;
				drem_q <= '0;
			end
			lbsb_pkg::ST_DIV: begin
				dvd_q  <= dvd_nx;
				drem_q <= dr_nx;
				rad_q  <= {dvd_nx, 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			lbsb_pkg::ST_LVL: begin
				rad_q  <= {rad_q[lbsb_pkg::RadW-3:0], 2'b00};
				rem_q  <= rem_nx;
				root_q <= root_nx;
			end
			lbsb_pkg::ST_PUSH: begin
				// The next band of a flush starts with an empty sum.
				dvd_q  <= '0;
				drem_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			last_q       <= 1'b0;
			bin_cnt_q    <= '0;
			band_idx_q   <= '0;
			band_start_q <= '0;
			band_end_q   <= BinW'(1);
			root_sum_q   <= '0;
			energy_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			unique case (state_q)
				lbsb_pkg::ST_IDLE: begin
					step_q <= '0;
					if (in_pop) begin
						last_q <= in_item.last_bin;
						if (done_q) begin
							if (in_item.last_bin) begin
								bin_cnt_q    <= '0;
								band_idx_q   <= '0;
								band_start_q <= '0;
								band_end_q   <= BinW'(1);
								root_sum_q   <= '0;
								energy_q     <= '0;
								done_q       <= 1'b0;
							end else begin
								bin_cnt_q <= bin_cnt_inc;
							end
						end
					end
				end
				lbsb_pkg::ST_ROOT, lbsb_pkg::ST_DIV, lbsb_pkg::ST_LVL: begin
					step_q <= step_last ? '0 : step_q + 1'b1;
					if (state_q == lbsb_pkg::ST_ROOT && step_last) begin
						root_sum_q <= root_sat;
						energy_q   <= energy_sat;
						bin_cnt_q  <= bin_cnt_inc;
					end
				end
				lbsb_pkg::ST_PUSH: begin
					step_q <= '0;
					if (out_push) begin
						if (last_q && frame_end) begin
							bin_cnt_q    <= '0;
							band_idx_q   <= '0;
							band_start_q <= '0;
							band_end_q   <= BinW'(1);
							root_sum_q   <= '0;
							energy_q     <= '0;
							done_q       <= 1'b0;
						end else begin
							band_idx_q   <= nx_idx;
							band_start_q <= band_end_q;
							root_sum_q   <= '0;
							if (frame_end)
								done_q <= 1'b1;
							else
								band_end_q <= nx_end;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/lbsb_checker.sv
// Port-level checks for log_band_spectrum_bars_unit and the bind that
// attaches them. Depends on lbsb_pkg and the top level.
`default_nettype none
module lbsb_checker #(
	parameter int BARS = 64
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        empty,
	input wire logic                        pop,
	input wire logic [lbsb_pkg::IdxW-1:0]   bar_index,
	input wire logic [lbsb_pkg::LevelW-1:0] bar_level,
	input wire logic [lbsb_pkg::SumW-1:0]   frame_energy,
	input wire logic                        last_bar
);
	localparam logic [lbsb_pkg::IdxW-1:0] LastIdx = lbsb_pkg::IdxW'(BARS - 1);

	// A result that is not taken stays on the ports.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(bar_index) && $stable(bar_level)
			&& $stable(frame_energy) && $stable(last_bar)))
		else $error("result changed while waiting for transfer");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_bar) |-> (bar_index == LastIdx))
		else $error("last_bar on a band other than the final one");

	// Bands of a frame come out in order and wrap to zero after the last one.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) ##1 !empty |->
			(bar_index == ($past(last_bar) ? '0 : $past(bar_index) + 1'b1)))
		else $error("band order broken");

	a_energy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_bar) ##1 !empty |-> (frame_energy >= $past(frame_energy)))
		else $error("frame energy fell within a frame");

endmodule

bind log_band_spectrum_bars_unit lbsb_checker #(.BARS(BARS)) u_lbsb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.bar_index   (bar_index),
	.bar_level   (bar_level),
	.frame_energy(frame_energy),
	.last_bar    (last_bar)
);
`default_nettype wire
